// File: rtl/pl0_pkg.sv
// ----------------------------------------------------------------------------
// pl0_pkg
// opcodes, sub-operation codes, error codes and divider link types
// ----------------------------------------------------------------------------
package pl0_pkg;

    localparam logic [3:0] OP_LIT   = 4'd0;
    localparam logic [3:0] OP_OPR   = 4'd1;
    localparam logic [3:0] OP_LOD   = 4'd2;
    localparam logic [3:0] OP_STO   = 4'd3;
    localparam logic [3:0] OP_CAL   = 4'd4;
    localparam logic [3:0] OP_INT   = 4'd5;
    localparam logic [3:0] OP_JMP   = 4'd6;
    localparam logic [3:0] OP_JPC   = 4'd7;
    localparam logic [3:0] OP_HALT  = 4'd8;
    localparam logic [3:0] OP_READ  = 4'd9;
    localparam logic [3:0] OP_WRITE = 4'd10;

    localparam logic signed [31:0] SUB_RET = 32'sd0;
    localparam logic signed [31:0] SUB_ADD = 32'sd1;
    localparam logic signed [31:0] SUB_SUB = 32'sd2;
    localparam logic signed [31:0] SUB_MUL = 32'sd3;
    localparam logic signed [31:0] SUB_DIV = 32'sd4;
    localparam logic signed [31:0] SUB_EQ  = 32'sd5;
    localparam logic signed [31:0] SUB_NEQ = 32'sd6;
    localparam logic signed [31:0] SUB_GE  = 32'sd7;
    localparam logic signed [31:0] SUB_LE  = 32'sd8;
    localparam logic signed [31:0] SUB_GT  = 32'sd9;
    localparam logic signed [31:0] SUB_LT  = 32'sd10;
    localparam logic signed [31:0] SUB_NEG = 32'sd11;
    localparam logic signed [31:0] SUB_ODD = 32'sd12;

    localparam logic [1:0] ERR_NONE  = 2'd0;
    localparam logic [1:0] ERR_OPC   = 2'd1;
    localparam logic [1:0] ERR_RANGE = 2'd2;
    localparam logic [1:0] ERR_DIV0  = 2'd3;

    typedef struct packed {
        logic               start;
        logic signed [31:0] dividend;
        logic signed [31:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic               done;
        logic signed [31:0] quotient;
    } div_rsp_t;

endpackage

// File: rtl/pl0_div.sv
// ----------------------------------------------------------------------------
// pl0_div
// radix-2 restoring signed divider, truncates toward zero, 32 steps
// ----------------------------------------------------------------------------
module pl0_div
    import pl0_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic [31:0] rem_reg;
    logic [31:0] quo_reg;
    logic [31:0] dvs_reg;
    logic        neg_reg;
    logic [5:0]  cnt_reg;
    logic        done_reg;
    logic [32:0] rem_sh;
    logic [32:0] diff;

    assign rem_sh = {rem_reg, quo_reg[31]};
    assign diff   = rem_sh - {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= (cnt_reg == 6'd1);
            if (req.start)
            begin
                cnt_reg <= 6'd32;
                neg_reg <= req.dividend[31] ^ req.divisor[31];
                rem_reg <= '0;
                quo_reg <= req.dividend[31] ? (32'd0 - req.dividend) : req.dividend;
                dvs_reg <= req.divisor[31] ? (32'd0 - req.divisor) : req.divisor;
            end
            else if (cnt_reg != 6'd0)
            begin
                cnt_reg <= cnt_reg - 6'd1;
                if (!diff[32])
                begin
                    rem_reg <= diff[31:0];
                    quo_reg <= {quo_reg[30:0], 1'b1};
                end
                else
                begin
                    rem_reg <= rem_sh[31:0];
                    quo_reg <= {quo_reg[30:0], 1'b0};
                end
            end
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = neg_reg ? $signed(32'd0 - quo_reg) : $signed(quo_reg);

endmodule

// File: rtl/pl0_pcode_stack_machine.sv
// ----------------------------------------------------------------------------
// pl0_pcode_stack_machine
// p-code interpreter core: one instruction per transaction on a stack memory
// ----------------------------------------------------------------------------
// cycles through S_EXEC and per-command states into S_FIN, or straight to S_FIN once stopped;
// lod/sto/read/write/cal walk one static link per level in S_WALK and S_LINK, div waits
// for the divider in S_DIV; range errors end early
// one instruction in flight; a stalled result register holds the core in its last state
// reset: a clearing pass over all STACK_DEPTH entries writes the initial stack,
// no transaction is accepted until it ends
module pl0_pcode_stack_machine
    import pl0_pkg::*;
#(
    parameter int STACK_DEPTH = 1024,
    parameter int MAX_LEVEL   = 15
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // command[3:0] level[7:4] operand[39:8] read_value[71:40]
    input  logic [71:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // next_pc[15:0] write_valid[16] write_value[48:17] halted[49] error_code[51:50]
    output logic [55:0] m_tdata
);

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int LW = $clog2(MAX_LEVEL + 1);
    localparam int IW = 35;
    localparam logic signed [IW-1:0] DEPTH_S = IW'(STACK_DEPTH);

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_EXEC, S_WALK, S_LINK, S_ADDR, S_ACC, S_LOD, S_STO,
        S_WOUT, S_CAL1, S_CAL2, S_CAL3, S_RET1, S_RET2, S_UN, S_BIN1, S_BIN2,
        S_BIN3, S_DIV, S_JPC, S_FIN
    } state_t;

    state_t             state_reg;
    logic [AW-1:0]      clr_reg;
    logic [AW-1:0]      top_reg;
    logic [AW-1:0]      base_reg;
    logic [15:0]        pc_reg;
    logic               stop_reg;
    logic [1:0]         err_reg;
    logic [3:0]         cmd_reg;
    logic [LW-1:0]      cnt_reg;
    logic signed [31:0] opnd_reg;
    logic [31:0]        rv_reg;
    logic [AW-1:0]      cur_reg;
    logic [AW-1:0]      addr_reg;
    logic signed [31:0] x_reg;
    logic signed [31:0] y_reg;
    logic               wv_reg;
    logic [31:0]        wval_reg;
    logic               m_tvalid_reg;
    logic [55:0]        m_tdata_reg;

    logic [31:0]        mem [STACK_DEPTH];
    logic [31:0]        rdata_reg;
    logic               mem_we;
    logic [AW-1:0]      mem_wa;
    logic [31:0]        mem_wd;
    logic [AW-1:0]      mem_ra;

    div_req_t           dreq;
    div_rsp_t           drsp;

    logic signed [IW-1:0] t_s, b_s, a_s, c_s, link_s;
    logic signed [IW-1:0] t_p1, t_m1, t_p3, t_pa, b_m1, b_m2, b_p1, addr_s;
    logic [31:0]          bin_r;
    logic [31:0]          mul_lo;
    logic                 s_acc;
    logic [LW-1:0]        lvl_cap;

    function automatic logic ok_idx(input logic signed [IW-1:0] x);
        return (x >= 0) && (x < DEPTH_S);
    endfunction

    assign t_s    = $signed({{(IW-AW){1'b0}}, top_reg});
    assign b_s    = $signed({{(IW-AW){1'b0}}, base_reg});
    assign c_s    = $signed({{(IW-AW){1'b0}}, cur_reg});
    assign a_s    = IW'(opnd_reg);
    assign link_s = IW'($signed(rdata_reg));
    assign t_p1   = t_s + 1;
    assign t_m1   = t_s - 1;
    assign t_p3   = t_s + 3;
    assign t_pa   = t_s + a_s;
    assign b_m1   = b_s - 1;
    assign b_m2   = b_s - 2;
    assign b_p1   = b_s + 1;
    assign addr_s = c_s + a_s + 2;
    assign mul_lo = x_reg * y_reg;

    assign s_tready = (state_reg == S_IDLE);
    assign s_acc    = s_tvalid && s_tready;
    assign lvl_cap  = ({4'd0, s_tdata[7:4]} > 8'(MAX_LEVEL)) ? LW'(MAX_LEVEL)
                                                              : LW'(s_tdata[7:4]);

    always_comb
    begin
        case (opnd_reg)
            SUB_SUB: bin_r = x_reg - y_reg;
            SUB_MUL: bin_r = mul_lo;
            SUB_EQ:  bin_r = {31'd0, x_reg == y_reg};
            SUB_NEQ: bin_r = {31'd0, x_reg != y_reg};
            SUB_GE:  bin_r = {31'd0, x_reg >= y_reg};
            SUB_LE:  bin_r = {31'd0, x_reg <= y_reg};
            SUB_GT:  bin_r = {31'd0, x_reg > y_reg};
            SUB_LT:  bin_r = {31'd0, x_reg < y_reg};
            default: bin_r = x_reg + y_reg;
        endcase
    end

    always_comb
    begin
        mem_we = 1'b0;
        mem_wa = top_reg;
        mem_wd = '0;
        mem_ra = top_reg;
        dreq.start    = 1'b0;
        dreq.dividend = x_reg;
        dreq.divisor  = y_reg;
        case (state_reg)
            S_CLEAR:
            begin
                mem_we = 1'b1;
                mem_wa = clr_reg;
                mem_wd = (clr_reg == AW'(1)) ? 32'd1 : 32'd0;
            end
            S_EXEC:
            begin
                if (cmd_reg == OP_LIT)
                begin
                    mem_we = ok_idx(t_p1);
                    mem_wa = t_p1[AW-1:0];
                    mem_wd = opnd_reg;
                end
                else if (cmd_reg == OP_OPR && opnd_reg == SUB_RET)
                    mem_ra = b_m1[AW-1:0];
                else if (cmd_reg == OP_OPR && opnd_reg >= SUB_ADD && opnd_reg <= SUB_LT)
                    mem_ra = t_m1[AW-1:0];
            end
            S_WALK: mem_ra = cur_reg;
            S_ACC:
            begin
                if (cmd_reg == OP_READ)
                begin
                    mem_we = 1'b1;
                    mem_wa = addr_reg;
                    mem_wd = rv_reg;
                end
                else if (cmd_reg != OP_STO)
                    mem_ra = addr_reg;
            end
            S_LOD:
            begin
                mem_we = 1'b1;
                mem_wa = t_p1[AW-1:0];
                mem_wd = rdata_reg;
            end
            S_STO:
            begin
                mem_we = 1'b1;
                mem_wa = addr_reg;
                mem_wd = rdata_reg;
            end
            S_CAL1:
            begin
                mem_we = 1'b1;
                mem_wa = t_p1[AW-1:0];
                mem_wd = 32'(base_reg);
            end
            S_CAL2:
            begin
                mem_we = 1'b1;
                mem_wa = AW'(t_s + 2);
                mem_wd = 32'(cur_reg);
            end
            S_CAL3:
            begin
                mem_we = 1'b1;
                mem_wa = t_p3[AW-1:0];
                mem_wd = 32'(pc_reg);
            end
            S_RET1: mem_ra = b_p1[AW-1:0];
            S_UN:
            begin
                mem_we = 1'b1;
                mem_wd = (opnd_reg == SUB_NEG) ? (32'd0 - rdata_reg) : {31'd0, rdata_reg[0]};
            end
            S_BIN1: mem_ra = top_reg;
            S_BIN3:
            begin
                mem_wa = t_m1[AW-1:0];
                if (opnd_reg == SUB_DIV)
                begin
                    mem_we     = (y_reg == 0);
                    dreq.start = (y_reg != 0);
                end
                else
                begin
                    mem_we = 1'b1;
                    mem_wd = bin_r;
                end
            end
            S_DIV:
            begin
                mem_we = drsp.done;
                mem_wa = t_m1[AW-1:0];
                mem_wd = drsp.quotient;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_wa] <= mem_wd;
        rdata_reg <= mem[mem_ra];
    end

    pl0_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (dreq),
        .rsp   (drsp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            clr_reg      <= '0;
            top_reg      <= AW'(2);
            base_reg     <= AW'(1);
            pc_reg       <= '0;
            stop_reg     <= 1'b0;
            err_reg      <= ERR_NONE;
            wv_reg       <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (m_tvalid_reg && m_tready && state_reg != S_FIN)
                m_tvalid_reg <= 1'b0;
            case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + AW'(1);
                    if (clr_reg == AW'(STACK_DEPTH - 1))
                        state_reg <= S_IDLE;
                end
                S_IDLE:
                begin
                    if (s_acc)
                    begin
                        cmd_reg  <= s_tdata[3:0];
                        cnt_reg  <= lvl_cap;
                        opnd_reg <= s_tdata[39:8];
                        rv_reg   <= s_tdata[71:40];
                        cur_reg  <= base_reg;
                        wv_reg   <= 1'b0;
                        wval_reg <= '0;
                        if (stop_reg)
                            state_reg <= S_FIN;
                        else
                        begin
                            pc_reg    <= pc_reg + 16'd1;
                            state_reg <= S_EXEC;
                        end
                    end
                end
                S_EXEC:
                begin
                    state_reg <= S_FIN;
                    case (cmd_reg)
                        OP_LIT:
                        begin
                            if (ok_idx(t_p1))
                                top_reg <= t_p1[AW-1:0];
                            else
                            begin
                                stop_reg <= 1'b1;
                                err_reg  <= ERR_RANGE;
                            end
                        end
                        OP_OPR:
                        begin
                            if (opnd_reg == SUB_RET)
                            begin
                                if (ok_idx(b_m2) && ok_idx(b_p1) && ok_idx(b_m1))
                                    state_reg <= S_RET1;
                                else
                                begin
                                    stop_reg <= 1'b1;
                                    err_reg  <= ERR_RANGE;
                                end
                            end
                            else if (opnd_reg == SUB_NEG || opnd_reg == SUB_ODD)
                                state_reg <= S_UN;
                            else if (opnd_reg >= SUB_ADD && opnd_reg <= SUB_LT)
                            begin
                                if (ok_idx(t_m1))
                                    state_reg <= S_BIN1;
                                else
                                begin
                                    stop_reg <= 1'b1;
                                    err_reg  <= ERR_RANGE;
                                end
                            end
                        end
                        OP_LOD, OP_STO, OP_READ, OP_WRITE, OP_CAL: state_reg <= S_WALK;
                        OP_INT:
                        begin
                            if (ok_idx(t_pa))
                                top_reg <= t_pa[AW-1:0];
                            else
                            begin
                                stop_reg <= 1'b1;
                                err_reg  <= ERR_RANGE;
                            end
                        end
                        OP_JMP: pc_reg <= opnd_reg[15:0];
                        OP_JPC:
                        begin
                            if (ok_idx(t_m1))
                                state_reg <= S_JPC;
                            else
                            begin
                                stop_reg <= 1'b1;
                                err_reg  <= ERR_RANGE;
                            end
                        end
                        OP_HALT: stop_reg <= 1'b1;
                        default:
                        begin
                            stop_reg <= 1'b1;
                            err_reg  <= ERR_OPC;
                        end
                    endcase
                end
                S_WALK:
                begin
                    if (cnt_reg != '0)
                        state_reg <= S_LINK;
                    else if (cmd_reg != OP_CAL)
                        state_reg <= S_ADDR;
                    else if (ok_idx(t_p3))
                        state_reg <= S_CAL1;
                    else
                    begin
                        stop_reg  <= 1'b1;
                        err_reg   <= ERR_RANGE;
                        state_reg <= S_FIN;
                    end
                end
                S_LINK:
                begin
                    if (ok_idx(link_s))
                    begin
                        cur_reg   <= link_s[AW-1:0];
                        cnt_reg   <= cnt_reg - LW'(1);
                        state_reg <= S_WALK;
                    end
                    else
                    begin
                        stop_reg  <= 1'b1;
                        err_reg   <= ERR_RANGE;
                        state_reg <= S_FIN;
                    end
                end
                S_ADDR:
                begin
                    addr_reg <= addr_s[AW-1:0];
                    if (!ok_idx(addr_s) || (cmd_reg == OP_LOD && !ok_idx(t_p1))
                        || (cmd_reg == OP_STO && !ok_idx(t_m1)))
                    begin
                        stop_reg  <= 1'b1;
                        err_reg   <= ERR_RANGE;
                        state_reg <= S_FIN;
                    end
                    else
                        state_reg <= S_ACC;
                end
                S_ACC:
                begin
                    case (cmd_reg)
                        OP_LOD:  state_reg <= S_LOD;
                        OP_STO:  state_reg <= S_STO;
                        OP_WRITE: state_reg <= S_WOUT;
                        default: state_reg <= S_FIN;
                    endcase
                end
                S_LOD:
                begin
                    top_reg   <= t_p1[AW-1:0];
                    state_reg <= S_FIN;
                end
                S_STO:
                begin
                    top_reg   <= t_m1[AW-1:0];
                    state_reg <= S_FIN;
                end
                S_WOUT:
                begin
                    wv_reg    <= 1'b1;
                    wval_reg  <= rdata_reg;
                    state_reg <= S_FIN;
                end
                S_CAL1: state_reg <= S_CAL2;
                S_CAL2: state_reg <= S_CAL3;
                S_CAL3:
                begin
                    base_reg  <= AW'(t_s + 2);
                    top_reg   <= t_p3[AW-1:0];
                    pc_reg    <= opnd_reg[15:0];
                    state_reg <= S_FIN;
                end
                S_RET1:
                begin
                    if (ok_idx(link_s))
                    begin
                        cur_reg   <= link_s[AW-1:0];
                        state_reg <= S_RET2;
                    end
                    else
                    begin
                        stop_reg  <= 1'b1;
                        err_reg   <= ERR_RANGE;
                        state_reg <= S_FIN;
                    end
                end
                S_RET2:
                begin
                    pc_reg    <= rdata_reg[15:0];
                    top_reg   <= b_m2[AW-1:0];
                    base_reg  <= cur_reg;
                    state_reg <= S_FIN;
                end
                S_UN: state_reg <= S_FIN;
                S_BIN1:
                begin
                    x_reg     <= rdata_reg;
                    state_reg <= S_BIN2;
                end
                S_BIN2:
                begin
                    y_reg     <= rdata_reg;
                    state_reg <= S_BIN3;
                end
                S_BIN3:
                begin
                    if (opnd_reg == SUB_DIV && y_reg != 0)
                        state_reg <= S_DIV;
                    else
                    begin
                        top_reg   <= t_m1[AW-1:0];
                        state_reg <= S_FIN;
                        if (opnd_reg == SUB_DIV)
                        begin
                            stop_reg <= 1'b1;
                            err_reg  <= ERR_DIV0;
                        end
                    end
                end
                S_DIV:
                begin
                    if (drsp.done)
                    begin
                        top_reg   <= t_m1[AW-1:0];
                        state_reg <= S_FIN;
                    end
                end
                S_JPC:
                begin
                    if (rdata_reg == 32'd0)
                        pc_reg <= opnd_reg[15:0];
                    top_reg   <= t_m1[AW-1:0];
                    state_reg <= S_FIN;
                end
                S_FIN:
                begin
                    if (!m_tvalid_reg || m_tready)
                    begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {4'd0, err_reg, stop_reg,
                                         (wv_reg && !stop_reg) ? wval_reg : 32'd0,
                                         wv_reg && !stop_reg, pc_reg};
                        state_reg    <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// File: rtl/pl0_chk.sv
// ----------------------------------------------------------------------------
// pl0_chk
// port-level checks on the command and result streams of the p-code core
// ----------------------------------------------------------------------------
module pl0_chk
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [55:0] m_tdata
);

    logic seen_halt_reg;
    logic out_acc;

    assign out_acc = m_tvalid && m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            seen_halt_reg <= 1'b0;
        else if (out_acc && m_tdata[49])
            seen_halt_reg <= 1'b1;
    end

    // stopped machine stays stopped
    a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        out_acc && seen_halt_reg |-> m_tdata[49])
        else $error("halted dropped");

    a_write_clean: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[16] |-> !m_tdata[49] && (m_tdata[51:50] == 2'd0))
        else $error("write with stop");

    a_err_halts: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[51:50] != 2'd0) |-> m_tdata[49])
        else $error("error without halt");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result not held");

    // one instruction at a time
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while busy");

endmodule

bind pl0_pcode_stack_machine pl0_chk u_pl0_chk (.*);
